// File: rtl/core/ialu_pkg.sv
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types and constants for the 32-bit integer ALU.
// ----------------------------------------------------------------------------
`default_nettype none
package ialu_pkg;

  localparam int unsigned DataWidth  = 32;
  localparam int unsigned ModeWidth  = 5;
  localparam int unsigned QueueDepth = 4;

  typedef enum logic [ModeWidth-1:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
    OP_EQ  = 5'd5, OP_NE  = 5'd6, OP_GT  = 5'd7, OP_GE  = 5'd8, OP_LT  = 5'd9,
    OP_LE  = 5'd10, OP_LAND = 5'd11, OP_LOR = 5'd12, OP_AND = 5'd13,
    OP_OR  = 5'd14, OP_XOR = 5'd15, OP_SHL = 5'd16, OP_SHR = 5'd17
  } op_t;

  typedef struct packed {
    logic [ModeWidth-1:0]        mode;
    logic signed [DataWidth-1:0] lhs;
    logic signed [DataWidth-1:0] rhs;
  } in_item_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] value;
    logic                        error;
  } out_item_t;

  // Item classified by the front end.
  typedef enum logic [1:0] {
    CLS_SIMPLE = 2'd0,
    CLS_MUL    = 2'd1,
    CLS_DIV    = 2'd2
  } cls_t;

  typedef struct packed {
    cls_t                   cls;
    logic                   want_rem;
    logic                   fixed;     // result already settled by front end
    logic [DataWidth-1:0]   a;
    logic [DataWidth-1:0]   b;
    out_item_t              res;       // settled result when fixed
  } work_t;

endpackage
`default_nettype wire

// File: rtl/core/ialu_front.sv
// ----------------------------------------------------------------------------
// ialu_front
// Classifies each item; settles simple operations and special cases at once.
// ----------------------------------------------------------------------------
`default_nettype none
module ialu_front
  import ialu_pkg::*;
(
  input  var in_item_t item,
  output var work_t    work
);

  logic signed [DataWidth-1:0] a, b;
  logic [DataWidth-1:0]        au, bu;
  logic                        shift_bad;
  logic [DataWidth-1:0]        shr_res;

  assign a  = item.lhs;
  assign b  = item.rhs;
  assign au = item.lhs;
  assign bu = item.rhs;
  assign shift_bad = (bu > DataWidth'(DataWidth - 1));
  assign shr_res   = DataWidth'(a >>> bu[4:0]);

  always_comb begin
    work          = '0;
    work.cls      = CLS_SIMPLE;
    work.fixed    = 1'b1;
    work.a        = au;
    work.b        = bu;
    work.want_rem = (item.mode == OP_MOD);
    case (item.mode)
      OP_ADD:  work.res.value = a + b;
      OP_SUB:  work.res.value = a - b;
      OP_MUL: begin
        work.cls   = CLS_MUL;
        work.fixed = 1'b0;
      end
      OP_DIV, OP_MOD: begin
        work.cls = CLS_DIV;
        if (bu == '0) begin
          work.res.error = 1'b1;
        end else if (au == {1'b1, {(DataWidth-1){1'b0}}} && bu == '1) begin
          work.res.error = 1'b1;
          work.res.value = (item.mode == OP_DIV) ? a : '0;
        end else begin
          work.fixed = 1'b0;
        end
      end
      OP_EQ:   work.res.value = DataWidth'(a == b);
      OP_NE:   work.res.value = DataWidth'(a != b);
      OP_GT:   work.res.value = DataWidth'(a > b);
      OP_GE:   work.res.value = DataWidth'(a >= b);
      OP_LT:   work.res.value = DataWidth'(a < b);
      OP_LE:   work.res.value = DataWidth'(a <= b);
      OP_LAND: work.res.value = DataWidth'(au != '0 && bu != '0);
      OP_LOR:  work.res.value = DataWidth'(au != '0 || bu != '0);
      OP_AND:  work.res.value = a & b;
      OP_OR:   work.res.value = a | b;
      OP_XOR:  work.res.value = a ^ b;
      OP_SHL: begin
        work.res.error = shift_bad;
        work.res.value = shift_bad ? '0 : (au << bu[4:0]);
      end
      OP_SHR: begin
        work.res.error = shift_bad;
        work.res.value = shift_bad ? '0 : shr_res;
      end
      default: work.res = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/ialu_queue.sv
// ----------------------------------------------------------------------------
// ialu_queue
// Small FIFO between the front end and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none
module ialu_queue
  import ialu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  var logic  clk,
  input  var logic  rst,
  input  var logic  push,
  input  var work_t push_data,
  output var logic  full,
  input  var logic  pop,
  output var work_t pop_data,
  output var logic  empty
);

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  work_t         mem [Depth];
  logic [AW-1:0] wptr, rptr;
  logic [AW:0]   count;

  assign full     = (count == (AW+1)'(Depth));
  assign empty    = (count == '0);
  assign pop_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == AW'(Depth - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == AW'(Depth - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/ialu_back.sv
// ----------------------------------------------------------------------------
// ialu_back
// Execution pipeline: fixed-latency lane carrying a pipelined radix-2
// divider, a registered multiplier and settled results, plus an output FIFO
// with a registered head.
// ----------------------------------------------------------------------------
`default_nettype none
module ialu_back
  import ialu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  var logic      clk,
  input  var logic      rst,
  input  var logic      in_valid,
  input  var work_t     in_work,
  output var logic      in_take,
  output var logic      out_valid,
  output var out_item_t out_item,
  input  var logic      out_stall
);

  // Pipeline: stage 0 = setup, stages 1..DataWidth = one quotient bit each,
  // stage DataWidth+1 = sign fixup / select.
  localparam int unsigned Stages = DataWidth + 2;
  localparam int unsigned OD     = Stages + Depth;
  localparam int unsigned OAW    = $clog2(OD + 1);
  localparam int unsigned PAW    = $clog2(OD);

  typedef struct packed {
    cls_t                 cls;
    logic                 want_rem;
    logic                 fixed;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] rem;
    logic [DataWidth-1:0] quo;
    logic [DataWidth-1:0] div;
    out_item_t            res;
  } stage_t;

  stage_t             st      [Stages];
  stage_t             st_next [Stages];
  logic               vld     [Stages];
  logic [DataWidth:0] shifted [1:DataWidth];
  logic [DataWidth:0] trial   [1:DataWidth];

  // Credit: accept only when the output FIFO has room for everything in
  // flight, so the pipeline never has to stall.
  logic [OAW-1:0] inflight;
  logic [OAW-1:0] mcount;
  logic           opush;
  logic           oload;
  logic           opop;
  logic           ovalid;
  out_item_t      odata;

  assign in_take = in_valid && ((inflight + mcount) < OAW'(OD));

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Stages; i++) begin
        vld[i] <= 1'b0;
      end
    end else begin
      vld[0] <= in_take;
      for (int i = 1; i < Stages; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_comb begin
    // Stage 0: operands into magnitudes; multiply registered here.
    st_next[0].cls      = in_work.cls;
    st_next[0].want_rem = in_work.want_rem;
    st_next[0].fixed    = in_work.fixed;
    st_next[0].neg_q    = in_work.a[DataWidth-1] ^ in_work.b[DataWidth-1];
    st_next[0].neg_r    = in_work.a[DataWidth-1];
    st_next[0].rem      = '0;
    st_next[0].quo      = in_work.a[DataWidth-1] ? (~in_work.a + 1'b1) : in_work.a;
    st_next[0].div      = in_work.b[DataWidth-1] ? (~in_work.b + 1'b1) : in_work.b;
    st_next[0].res      = in_work.res;
    if (in_work.cls == CLS_MUL) begin
      st_next[0].res.value = DataWidth'(in_work.a * in_work.b);
      st_next[0].res.error = 1'b0;
    end

    // Stages 1..DataWidth: one restoring-division step each.
    for (int i = 1; i <= DataWidth; i++) begin
      shifted[i] = {st[i-1].rem, st[i-1].quo[DataWidth-1]};
      trial[i]   = shifted[i] - {1'b0, st[i-1].div};
      st_next[i] = st[i-1];
      if (trial[i][DataWidth]) begin
        st_next[i].rem = shifted[i][DataWidth-1:0];
        st_next[i].quo = {st[i-1].quo[DataWidth-2:0], 1'b0};
      end else begin
        st_next[i].rem = trial[i][DataWidth-1:0];
        st_next[i].quo = {st[i-1].quo[DataWidth-2:0], 1'b1};
      end
    end

    // Last stage: apply signs and pick the result.
    st_next[Stages-1] = st[Stages-2];
    if (st[Stages-2].cls == CLS_DIV && !st[Stages-2].fixed) begin
      st_next[Stages-1].res.error = 1'b0;
      if (st[Stages-2].want_rem) begin
        st_next[Stages-1].res.value = st[Stages-2].neg_r ? (~st[Stages-2].rem + 1'b1)
                                                         : st[Stages-2].rem;
      end else begin
        st_next[Stages-1].res.value = st[Stages-2].neg_q ? (~st[Stages-2].quo + 1'b1)
                                                         : st[Stages-2].quo;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < Stages; i++) begin
      st[i] <= st_next[i];
    end
  end

  // Output FIFO; the head beat is read into a register.
  out_item_t      omem [OD];
  logic [PAW-1:0] owp, orp;

  assign opush     = vld[Stages-1];
  assign opop      = ovalid && !out_stall;
  assign oload     = (mcount != '0) && (!ovalid || opop);
  assign out_valid = ovalid;
  assign out_item  = odata;

  always_ff @(posedge clk) begin
    if (opush) begin
      omem[owp] <= st[Stages-1].res;
    end
    if (oload) begin
      odata <= omem[orp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owp      <= '0;
      orp      <= '0;
      mcount   <= '0;
      inflight <= '0;
      ovalid   <= 1'b0;
    end else begin
      if (opush) begin
        owp <= (owp == PAW'(OD - 1)) ? '0 : owp + 1'b1;
      end
      if (oload) begin
        orp <= (orp == PAW'(OD - 1)) ? '0 : orp + 1'b1;
      end
      if (oload) begin
        ovalid <= 1'b1;
      end else if (opop) begin
        ovalid <= 1'b0;
      end
      mcount   <= mcount + OAW'(opush) - OAW'(oload);
      inflight <= inflight + OAW'(in_take) - OAW'(opush);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/integer_alu_binary_ops.sv
// ----------------------------------------------------------------------------
// integer_alu_binary_ops
// 32-bit signed integer ALU with decoupled classify and execute halves.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) carries mode, lhs and rhs.
//   Output channel (out_valid/out_stall/out_data) returns value and error,
//   one result beat per input beat, in order.
//   The front end classifies each beat and settles simple operations and
//   the flagged special cases, then pushes it into a 4-entry queue.
//   The back end runs every beat through one fixed-length lane: a setup
//   stage (which also holds the registered multiply), 32 radix-2 divider
//   steps and a sign-fixup stage, then the output FIFO and its registered
//   head. Throughput is one beat per cycle while the output FIFO has
//   room for it, since the divider is fully pipelined.
//   An output FIFO sized for the whole lane plus slack absorbs results when
//   the receiver stalls; the back end holds off pulling from the queue once
//   that FIFO could overflow, and the queue then fills and raises in_stall.
//   Synchronous reset drops all beats in flight and empties every queue.
// ----------------------------------------------------------------------------
`default_nettype none
module integer_alu_binary_ops
  import ialu_pkg::*;
#(
  parameter int unsigned Depth = QueueDepth
) (
  input  var logic      clk,
  input  var logic      rst,
  input  var logic      in_valid,
  output var logic      in_stall,
  input  var in_item_t  in_data,
  output var logic      out_valid,
  input  var logic      out_stall,
  output var out_item_t out_data
);

  work_t front_work;
  work_t q_work;
  logic  q_full, q_empty, take;

  ialu_front u_front (
    .item (in_data),
    .work (front_work)
  );

  // Stall the sender only while the queue is full.
  assign in_stall = q_full;

  ialu_queue #(.Depth(Depth)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && !q_full),
    .push_data (front_work),
    .full      (q_full),
    .pop       (take),
    .pop_data  (q_work),
    .empty     (q_empty)
  );

  ialu_back #(.Depth(Depth)) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!q_empty),
    .in_work   (q_work),
    .in_take   (take),
    .out_valid (out_valid),
    .out_item  (out_data),
    .out_stall (out_stall)
  );

endmodule
`default_nettype wire

// File: bench/alu_scoreboard.sv
// ----------------------------------------------------------------------------
// alu_scoreboard
// Predicts each ALU result from an accepted beat and checks results in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
class alu_scoreboard;
  ialu_pkg::out_item_t pending_results[$];
  int mismatches = 0;

  function ialu_pkg::out_item_t compute(ialu_pkg::in_item_t it);
    ialu_pkg::out_item_t r;
    logic signed [31:0] a, b;
    logic [63:0] prod;
    a = it.lhs;
    b = it.rhs;
    r.value = '0;
    r.error = 1'b0;
    case (it.mode)
      ialu_pkg::OP_ADD: r.value = a + b;
      ialu_pkg::OP_SUB: r.value = a - b;
      ialu_pkg::OP_MUL: begin
        prod = {32'd0, a} * {32'd0, b};
        r.value = prod[31:0];
      end
      ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
        if (b == 0) begin
          r.error = 1'b1;
        end else if (a == 32'sh8000_0000 && b == -32'sd1) begin
          r.error = 1'b1;
          r.value = (it.mode == ialu_pkg::OP_DIV) ? 32'sh8000_0000 : 32'sd0;
        end else if (it.mode == ialu_pkg::OP_DIV) begin
          r.value = a / b;
        end else begin
          r.value = a % b;
        end
      end
      ialu_pkg::OP_EQ:   r.value = {31'd0, a == b};
      ialu_pkg::OP_NE:   r.value = {31'd0, a != b};
      ialu_pkg::OP_GT:   r.value = {31'd0, a > b};
      ialu_pkg::OP_GE:   r.value = {31'd0, a >= b};
      ialu_pkg::OP_LT:   r.value = {31'd0, a < b};
      ialu_pkg::OP_LE:   r.value = {31'd0, a <= b};
      ialu_pkg::OP_LAND: r.value = {31'd0, (a != 0) && (b != 0)};
      ialu_pkg::OP_LOR:  r.value = {31'd0, (a != 0) || (b != 0)};
      ialu_pkg::OP_AND:  r.value = a & b;
      ialu_pkg::OP_OR:   r.value = a | b;
      ialu_pkg::OP_XOR:  r.value = a ^ b;
      ialu_pkg::OP_SHL, ialu_pkg::OP_SHR: begin
        if (b < 0 || b > 31) r.error = 1'b1;
        else if (it.mode == ialu_pkg::OP_SHL) r.value = a << b[4:0];
        else r.value = a >>> b[4:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  function void note_operation(ialu_pkg::in_item_t it);
    pending_results.push_back(compute(it));
  endfunction

  task report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  task check_result(ialu_pkg::out_item_t got);
    ialu_pkg::out_item_t want;
    if (pending_results.size() == 0) begin
      report("unexpected result", got.value, 32'd0);
      return;
    end
    want = pending_results.pop_front();
    if (got.value !== want.value) report("value", got.value, want.value);
    if (got.error !== want.error) report("error", {31'd0, got.error}, {31'd0, want.error});
  endtask
endclass

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random ALU beats with random idling and a long output
// hold-off; checks each result in order against a predicted value and flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import ialu_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  alu_scoreboard alu_sb = new();
  bit quiet_phase = 1'b0;   // no idling near the end
  bit hold_done = 1'b0;
  int beats_sent = 0;

  integer_alu_binary_ops DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Note accepted input beats and check accepted results at each edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) alu_sb.note_operation(in_data);
    if (!rst && out_valid && !out_stall) alu_sb.check_result(out_data);
  end

  // Pick an operand biased toward the edges of the range.
  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40) - 8;
      5: return -$urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  // Offer one beat and hold it until accepted; idle first at random.
  task automatic send_beat(logic [4:0] m, logic [31:0] a, logic [31:0] b);
    int gap;
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{mode: m, lhs: a, rhs: b};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Receiver: one long hold-off early on, then random stall bursts.
  initial begin
    int n;
    @(negedge rst);
    @(posedge clk);
    while (beats_sent < 30) @(posedge clk);
    out_stall <= 1'b1;
    repeat (200) @(posedge clk);
    hold_done = 1'b1;
    forever begin
      if (!quiet_phase && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 10);
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
    end
  end

  initial begin
    int i, lat;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every operation plus the flagged cases and field extremes.
    for (i = 0; i <= OP_SHR; i++) send_beat(i[4:0], 32'h8000_0001, 32'd3);
    send_beat(OP_DIV, 32'd7, 32'd0);
    send_beat(OP_MOD, 32'h8000_0000, 32'd0);
    send_beat(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_MOD, 32'h8000_0000, 32'hffff_ffff);
    send_beat(OP_SHL, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OP_SHR, 32'h8000_0000, 32'd32);
    send_beat(OP_SHR, 32'h8000_0000, 32'd31);
    send_beat(OP_SHL, 32'hffff_ffff, 32'd31);
    send_beat(5'd31, 32'hffff_ffff, 32'hffff_ffff);
    send_beat(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    // Random: mostly valid codes, some unused ones.
    for (i = 0; i < 1900; i++) begin
      if (i == 1700) quiet_phase = 1'b1;
      send_beat(($urandom_range(0, 19) == 0) ? 5'($urandom_range(18, 31))
                : 5'($urandom_range(0, 17)), pick_operand(), pick_operand());
    end
    in_valid <= 1'b0;
    while (!hold_done || alu_sb.pending_results.size() != 0) @(posedge clk);
    lat = 0;
    while (lat < 40) begin
      @(posedge clk);
      lat++;
    end
    if (alu_sb.mismatches == 0 && alu_sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("FAIL");
    $finish;
  end
endmodule
